// ===== sv/mvt_pkg.sv =====
package mvt_pkg;

  // Fixed point defaults.
  localparam int FRAC_BITS_DEF = 16;

  // Depth of the queue between the front and back ends.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_COL_MAJOR = 2'd1,
    OP_ROW_MAJOR = 2'd2
  } opcode_t;

  // Payload of one incoming request.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
  } req_t;

  // Payload of one result.
  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic               clipped;
  } rsp_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic              is_load;
    logic              row_major;
    logic [3:0]        entry_index;
    logic [31:0]       entry_value;
    logic [3:0][31:0]  vec;
  } cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== sv/mvt_front.sv =====
module mvt_front
  import mvt_pkg::*;
(
  input  logic   req_valid,
  output logic   req_ready,
  input  req_t   req_data,
  input  qstat_t qstat,
  output logic   push,
  output cmd_t   cmd
);

  logic op_known;

  // The front end takes a request whenever the queue has room.
  assign req_ready = !qstat.full;

  // Only the three defined operations reach the queue; others are dropped.
  always_comb begin
    case (req_data.opcode)
      OP_LOAD, OP_COL_MAJOR, OP_ROW_MAJOR: op_known = 1'b1;
      default: op_known = 1'b0;
    endcase
  end

  assign push = req_valid && req_ready && op_known;

  // Classify the request and pack the fields the back end needs.
  always_comb begin
    cmd.is_load     = (req_data.opcode == OP_LOAD);
    cmd.row_major   = (req_data.opcode == OP_ROW_MAJOR);
    cmd.entry_index = req_data.entry_index;
    cmd.entry_value = req_data.entry_value;
    cmd.vec[0]      = req_data.vec_x;
    cmd.vec[1]      = req_data.vec_y;
    cmd.vec[2]      = req_data.vec_z;
    cmd.vec[3]      = req_data.vec_w;
  end

endmodule

// ===== sv/mvt_queue.sv =====
module mvt_queue
  import mvt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_data,
  input  logic   pop,
  output cmd_t   pop_data,
  output qstat_t qstat
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign qstat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign pop_data    = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mvt_back.sv =====
module mvt_back
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  qstat_t qstat,
  input  cmd_t   cmd,
  output logic   pop,
  output logic   rsp_valid,
  input  logic   rsp_ready,
  output rsp_t   rsp_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state;
  logic signed [31:0] mat   [16];
  logic signed [31:0] w     [16];
  logic signed [31:0] vec   [4];
  logic signed [63:0] mul   [4];
  logic signed [63:0] prod  [4];
  logic signed [64:0] pair  [2];
  logic signed [31:0] res   [4];
  logic               clip;
  logic [2:0]         issue_cnt;
  logic               s1_valid;
  logic [1:0]         s1_comp;
  logic               s2_valid;
  logic [1:0]         s2_comp;
  logic signed [65:0] sum;
  logic signed [65:0] shifted;
  logic               fits;
  logic signed [31:0] sat_val;

  // A command is taken from the queue only while the back end is idle.
  assign pop = (state == ST_IDLE) && !qstat.empty;

  // One multiplier per vector component; taps sit at the head of each column.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mul[k] = w[k*4] * vec[k];
    end
  end

  // Final add, floor shift and saturation of one result component.
  always_comb begin
    sum     = 66'(pair[0]) + 66'(pair[1]);
    shifted = sum >>> FRAC_BITS;
    fits    = (&shifted[65:31]) || !(|shifted[65:31]);
    if (fits) begin
      sat_val = shifted[31:0];
    end else if (shifted[65]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7fff_ffff;
    end
  end

  // Payload datapath: products and pair sums need no reset.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      prod[k] <= mul[k];
    end
    pair[0] <= 65'(prod[0]) + 65'(prod[1]);
    pair[1] <= 65'(prod[2]) + 65'(prod[3]);
  end

  // Sequencer, matrix store and result assembly.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      for (int j = 0; j < 16; j++) begin
        mat[j] <= '0;
      end
    end else begin
      // A component enters the multiplier on every issuing cycle.
      s1_valid <= (state == ST_RUN) && (issue_cnt != 3'd4);
      s2_valid <= s1_valid;
      s2_comp  <= s1_comp;
      // The output register empties on a handshake unless a new vector replaces it.
      if (rsp_valid && rsp_ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            if (cmd.is_load) begin
              mat[cmd.entry_index] <= $signed(cmd.entry_value);
            end else begin
              // Snapshot the matrix so that column k holds the coefficients
              // for vector component k, one result component per row.
              for (int k = 0; k < 4; k++) begin
                for (int i = 0; i < 4; i++) begin
                  w[k*4+i] <= cmd.row_major ? mat[i*4+k] : mat[k*4+i];
                end
                vec[k] <= $signed(cmd.vec[k]);
              end
              issue_cnt <= '0;
              clip      <= 1'b0;
              state     <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          // Issue one result component per cycle and step the taps along.
          if (issue_cnt != 3'd4) begin
            for (int j = 0; j < 15; j++) begin
              w[j] <= w[j+1];
            end
            s1_comp   <= issue_cnt[1:0];
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (s2_valid) begin
            res[s2_comp] <= sat_val;
            clip         <= clip || !fits;
            if (s2_comp == 2'd3) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // Hand the finished vector to the output register once it is free.
          if (!rsp_valid || rsp_ready) begin
            rsp_data.res_x   <= res[0];
            rsp_data.res_y   <= res[1];
            rsp_data.res_z   <= res[2];
            rsp_data.res_w   <= res[3];
            rsp_data.clipped <= clip;
            rsp_valid        <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/matrix_vector_transform_4x4.sv =====
// 4x4 matrix by 4-vector transform in signed fixed point with FRAC_BITS
// fraction bits. A load request writes one matrix entry (index col*4+row)
// and returns nothing; a column-major or row-major transform request returns
// one saturated 4-vector with a clipped flag. Requests pass through a
// two-entry queue, so the port keeps accepting while the back end works and
// while a result waits on rsp_ready, until the queue is full. In a transform
// the back end's four 32x32 multipliers produce one result component per
// cycle, followed by a two-stage add, shift and saturate path and a handoff
// to the output register. Requests are carried out strictly in order, so a
// load takes effect for every later transform.
module matrix_vector_transform_4x4
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  qstat_t qstat;
  logic   q_push;
  logic   q_pop;
  cmd_t   q_in;
  cmd_t   q_out;

  // Request decode and admission.
  mvt_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .qstat     (qstat),
    .push      (q_push),
    .cmd       (q_in)
  );

  // Command queue between the two ends.
  mvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .qstat     (qstat)
  );

  // Matrix store and transform datapath.
  mvt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .cmd       (q_out),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // The queue is never written while full.
  assert property (@(posedge clk) disable iff (rst) !(q_push && qstat.full))
    else $error("queue written while full");

  // The back end never reads an empty queue.
  assert property (@(posedge clk) disable iff (rst) !(q_pop && qstat.empty))
    else $error("queue read while empty");

  // An undefined operation is accepted but never queued.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_data.opcode != OP_LOAD &&
     req_data.opcode != OP_COL_MAJOR && req_data.opcode != OP_ROW_MAJOR) |-> !q_push)
    else $error("undefined operation queued");

endmodule

// ===== tb/sv/mvt_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the matrix-vector transform block. It keeps its own
// copy of the matrix, predicts one result for every accepted transform
// request and compares each accepted result with the oldest prediction.
module mvt_result_checker
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp_data,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned checked,
  output int unsigned saturated
);

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  // Matrix copy, column-major (col*4+row), and the results still owed.
  logic signed [31:0] matrix_copy [16];
  rsp_t               expected_results [$];

  // Multiply the held matrix by the request vector. Products are exact, the
  // sum is floored by the fraction bits and then clamped to 32 bits.
  function automatic rsp_t transform_vector(input req_t r);
    logic signed [31:0] vec [4];
    logic signed [31:0] comp [4];
    logic signed [31:0] entry;
    logic signed [63:0] prod;
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    logic               clip;
    rsp_t               o;
    vec[0] = r.vec_x;
    vec[1] = r.vec_y;
    vec[2] = r.vec_z;
    vec[3] = r.vec_w;
    clip = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        entry = (r.opcode == OP_COL_MAJOR) ? matrix_copy[k*4+i] : matrix_copy[i*4+k];
        prod = 64'(entry) * 64'(vec[k]);
        acc = acc + prod;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > SAT_HI) begin
        comp[i] = 32'h7FFF_FFFF;
        clip = 1'b1;
      end else if (scaled < SAT_LO) begin
        comp[i] = 32'h8000_0000;
        clip = 1'b1;
      end else begin
        comp[i] = scaled[31:0];
      end
    end
    o.res_x = comp[0];
    o.res_y = comp[1];
    o.res_z = comp[2];
    o.res_w = comp[3];
    o.clipped = clip;
    return o;
  endfunction

  // Print one differing field; returns 1 when it differs.
  function automatic bit field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, name, $signed(want), want, $signed(got), got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Results are compared before the request of the same edge is applied,
  // since a result can only come from an earlier request.
  always @(posedge clk) begin
    rsp_t want;
    bit   bad;
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        matrix_copy[i] = '0;
      end
      expected_results.delete();
      mismatches <= 0;
      outstanding <= 0;
      checked <= 0;
      saturated <= 0;
    end else begin
      bad = 1'b0;
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting, actual 0x%h", $time, rsp_data);
          bad = 1'b1;
        end else begin
          want = expected_results.pop_front();
          bad |= field_differs("res_x", want.res_x, rsp_data.res_x);
          bad |= field_differs("res_y", want.res_y, rsp_data.res_y);
          bad |= field_differs("res_z", want.res_z, rsp_data.res_z);
          bad |= field_differs("res_w", want.res_w, rsp_data.res_w);
          bad |= field_differs("clipped", 32'(want.clipped), 32'(rsp_data.clipped));
          checked <= checked + 1;
          if (want.clipped) begin
            saturated <= saturated + 1;
          end
        end
      end
      if (bad) begin
        mismatches <= mismatches + 1;
      end

      // Apply the accepted request: loads update the copy, transforms owe a result.
      if (req_valid && req_ready) begin
        case (req_data.opcode)
          OP_LOAD: begin
            matrix_copy[req_data.entry_index] = req_data.entry_value;
          end
          OP_COL_MAJOR, OP_ROW_MAJOR: begin
            expected_results.push_back(transform_vector(req_data));
          end
          default: begin
          end
        endcase
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mvt_pkg::*;

  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam logic [31:0] W_MAX           = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN           = 32'h8000_0000;
  localparam logic [31:0] W_ONE           = 32'h0001_0000;
  localparam int          STALL_LIMIT     = 2000;
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          ITEMS_PER_PHASE = 175;
  localparam int          LONG_HOLD       = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned saturated;

  int send_idle_pct = 35;
  int recv_idle_pct = 61;
  int long_hold_req = 0;
  int quiet_cycles  = 0;
  int n_loads       = 0;
  int n_transforms  = 0;
  int n_ignored     = 0;

  always #4 clk = ~clk;

  matrix_vector_transform_4x4 i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  mvt_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .saturated   (saturated)
  );

  // Result receiver: random back-pressure, or a long hold-off when asked.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req != 0) begin
        hold_left = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left != 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too many cycles in a row with no request and no result moving.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL matrix_vector_transform_4x4");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic req_t build_request(input logic [1:0] op, input logic [3:0] idx,
                                         input logic [31:0] val, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input logic [31:0] w);
    req_t r;
    r.opcode = op;
    r.entry_index = idx;
    r.entry_value = val;
    r.vec_x = x;
    r.vec_y = y;
    r.vec_z = z;
    r.vec_w = w;
    return r;
  endfunction

  // Q16.16 word: mostly small values so sums stay in range, some corners,
  // some full-range words that tend to saturate.
  function automatic logic [31:0] random_q16();
    int unsigned pick;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0: w = W_MAX;
        1: w = W_MIN;
        2: w = '0;
        default: w = '1;
      endcase
    end else if (pick < 65) begin
      w = $urandom_range(0, 32'h000F_FFFF);
      w = w - 32'h0008_0000;
    end else begin
      w = $urandom;
    end
    return w;
  endfunction

  function automatic req_t random_request();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      return build_request(OP_LOAD, 4'($urandom), random_q16(), $urandom, $urandom,
                           $urandom, $urandom);
    end
    if (pick < 95) begin
      op = (pick < 68) ? OP_COL_MAJOR : OP_ROW_MAJOR;
      return build_request(op, 4'($urandom), $urandom, random_q16(), random_q16(),
                           random_q16(), random_q16());
    end
    return build_request(OP_UNUSED, 4'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom);
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_req(input req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    case (r.opcode)
      OP_LOAD: n_loads++;
      OP_COL_MAJOR, OP_ROW_MAJOR: n_transforms++;
      default: n_ignored++;
    endcase
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
  endtask

  // Random traffic, partly whole matrix loads followed by the four columns
  // of a second matrix, as a full 4x4 multiply would be sent.
  task automatic run_random_phase(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        for (int i = 0; i < 16; i++) begin
          send_req(build_request(OP_LOAD, 4'(i), random_q16(), $urandom, $urandom,
                                 $urandom, $urandom));
        end
        for (int c = 0; c < 4; c++) begin
          send_req(build_request(OP_COL_MAJOR, 4'($urandom), $urandom, random_q16(),
                                 random_q16(), random_q16(), random_q16()));
        end
        sent += 20;
      end else begin
        send_req(random_request());
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] corner;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Transform of the all-zero matrix right after reset.
    send_req(build_request(OP_COL_MAJOR, '1, W_MAX, W_MAX, W_MIN, '1, W_ONE));

    // Load every entry with a corner value; vector fields carry noise.
    for (int i = 0; i < 16; i++) begin
      case (i % 8)
        0: corner = W_MAX;
        1: corner = W_MIN;
        2: corner = '0;
        3: corner = '1;
        4: corner = W_ONE;
        5: corner = -W_ONE;
        6: corner = 32'h0000_0001;
        default: corner = 32'h0001_8000;
      endcase
      send_req(build_request(OP_LOAD, 4'(i), corner, $urandom, $urandom, $urandom,
                             $urandom));
    end

    // Both orders at the vector extremes, saturating both ways.
    send_req(build_request(OP_COL_MAJOR, '0, '0, W_MAX, W_MIN, W_MAX, W_MIN));
    send_req(build_request(OP_ROW_MAJOR, '0, '0, W_MAX, W_MIN, W_MAX, W_MIN));
    // The unused opcode must change nothing and return nothing.
    send_req(build_request(OP_UNUSED, '1, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX));
    // Transforms ignore the entry fields.
    send_req(build_request(OP_COL_MAJOR, '1, W_MAX, W_ONE, '0, '0, '0));
    send_req(build_request(OP_ROW_MAJOR, 4'hA, W_MIN, '1, '1, '1, '1));
    send_req(build_request(OP_COL_MAJOR, '0, '0, W_MIN, W_MIN, W_MIN, W_MIN));
    send_req(build_request(OP_ROW_MAJOR, '0, '0, W_MAX, W_MAX, W_MAX, W_MAX));
    send_req(build_request(OP_COL_MAJOR, '0, '0, '0, '0, '0, '0));
    wait_drained();

    // Sender sparse, receiver slow.
    run_random_phase(ITEMS_PER_PHASE);
    wait_drained();

    // Sender slow, receiver sparse.
    send_idle_pct = 61;
    recv_idle_pct = 35;
    run_random_phase(ITEMS_PER_PHASE);
    wait_drained();

    // No idling; first fill the block behind a long output stall.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = LONG_HOLD;
    for (int n = 0; n < 12; n++) begin
      send_req(build_request(OP_ROW_MAJOR, 4'($urandom), $urandom, random_q16(),
                             random_q16(), random_q16(), random_q16()));
    end
    wait_drained();
    run_random_phase(ITEMS_PER_PHASE);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Sent %0d loads, %0d transforms and %0d unused-opcode requests over three",
             n_loads, n_transforms, n_ignored);
    $display("idle mixes and a long output stall; %0d results checked, %0d saturated.",
             checked, saturated);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS matrix_vector_transform_4x4");
    end else begin
      $display("FAIL matrix_vector_transform_4x4");
    end
    $finish;
  end

endmodule
